/* rtl/core/coalescing_command_queue_assert.svh */
// Assertion macros for the coalescing command queue checker.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef COALESCING_COMMAND_QUEUE_ASSERT_SVH
`define COALESCING_COMMAND_QUEUE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define CCQ_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ccq assertion failed");

// antecedent implies consequent in the next cycle
`define CCQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ccq assertion failed");

`endif

/* rtl/core/ccq_pkg.sv */
// Shared types, codes and helpers of the coalescing command queue.
// No dependencies.
package ccq_pkg;
	localparam int ARGS_W = 53;
	localparam int PV_W = 48;
	localparam int GEN_W = 32;
	localparam int KEY_W = 45;

	typedef enum logic [1:0] {CLS_BYPASS, CLS_COAL, CLS_FIFO, CLS_DRAIN} cls_t;

	typedef enum logic [1:0] {
		RES_ACCEPT = 2'd0,
		RES_REJECT = 2'd1,
		RES_EXEC = 2'd2,
		RES_DONE = 2'd3
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_FIFO_WR, ST_SC_RD, ST_SC_CMP, ST_SC_END, ST_RESP,
		ST_DF_RD, ST_DF_CHK, ST_DS_RD, ST_DS_CHK, ST_DONE
	} state_t;

	typedef struct packed {
		logic [ARGS_W-1:0] args;
		logic [PV_W-1:0] pv;
		logic [GEN_W-1:0] gen;
	} entry_t;

	typedef struct packed {
		cls_t cls;
		entry_t ent;
		logic [GEN_W-1:0] active;
	} cmd_t;

	typedef struct packed {
		res_t rtype;
		logic [ARGS_W-1:0] args;
		logic [PV_W-1:0] pv;
		logic is_last;
		logic [5:0] consumed;
		logic [6:0] total;
	} result_t;

	function automatic logic [KEY_W-1:0] key_of(input entry_t e);
		return {e.pv[47:32], e.args[52:24]};
	endfunction

	function automatic logic is_stale(input logic [GEN_W-1:0] g, input logic [GEN_W-1:0] a);
		return (g != '0) && (g != a);
	endfunction
endpackage

/* rtl/core/ccq_ifs.sv */
// Channel interfaces of the coalescing command queue: request, response, config.
// No dependencies.
interface ccq_req_if;
	logic valid;
	logic ready;
	logic cmd;
	logic bypass;
	logic [4:0] kind;
	logic [7:0] arg_a;
	logic [7:0] arg_b;
	logic [7:0] arg_c;
	logic [7:0] arg_d;
	logic [15:0] wide_arg;
	logic [15:0] param_key;
	logic [31:0] payload_value;
	logic [31:0] generation;
	logic [31:0] live_generation;
	modport source(output valid, cmd, bypass, kind, arg_a, arg_b, arg_c, arg_d, wide_arg,
		param_key, payload_value, generation, live_generation, input ready);
	modport sink(input valid, cmd, bypass, kind, arg_a, arg_b, arg_c, arg_d, wide_arg,
		param_key, payload_value, generation, live_generation, output ready);
endinterface

interface ccq_rsp_if;
	logic valid;
	logic ready;
	logic [1:0] result_type;
	logic [4:0] out_kind;
	logic [7:0] out_a;
	logic [7:0] out_b;
	logic [7:0] out_c;
	logic [7:0] out_d;
	logic [15:0] out_wide;
	logic [15:0] out_param;
	logic [31:0] out_value;
	logic is_last;
	logic [5:0] consumed;
	logic [6:0] queued_total;
	modport source(output valid, result_type, out_kind, out_a, out_b, out_c, out_d, out_wide,
		out_param, out_value, is_last, consumed, queued_total, input ready);
	modport sink(input valid, result_type, out_kind, out_a, out_b, out_c, out_d, out_wide,
		out_param, out_value, is_last, consumed, queued_total, output ready);
endinterface

interface ccq_cfg_if;
	logic valid;
	logic ready;
	logic [31:0] data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

/* rtl/core/ccq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ccq_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input logic clk,
	input logic we,
	input logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
	input logic [W-1:0] wdata,
	input logic re,
	input logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
	output logic [W-1:0] rdata
);
	logic [W-1:0] mem [D];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

/* rtl/core/ccq_front.sv */
// Front end: config register, item intake, classification, two-entry command queue.
// Depends on ccq_pkg and ccq_ifs.
module ccq_front (
	input logic clk,
	input logic arst_n,
	ccq_cfg_if.sink cfg,
	ccq_req_if.sink req,
	output ccq_pkg::cmd_t head,
	output logic head_valid,
	input logic head_pop
);
	logic [31:0] mask_q;
	logic [1:0] cnt_q;
	ccq_pkg::cmd_t ent0_q, ent1_q, new_cmd;
	logic push;
	logic wr_idx;

	assign cfg.ready = 1'b1;
	assign req.ready = (cnt_q != 2'd2);
	assign push = req.valid && req.ready;
	assign wr_idx = (cnt_q - {1'b0, head_pop}) != 2'd0;

	always_comb begin
		new_cmd.ent.args = {req.kind, req.arg_a, req.arg_b, req.arg_c, req.arg_d, req.wide_arg};
		new_cmd.ent.pv = {req.param_key, req.payload_value};
		new_cmd.ent.gen = req.generation;
		new_cmd.active = req.live_generation;
		if (req.cmd) begin
			new_cmd.cls = ccq_pkg::CLS_DRAIN;
		end else if (req.bypass) begin
			new_cmd.cls = ccq_pkg::CLS_BYPASS;
		end else if (mask_q[req.kind]) begin
			new_cmd.cls = ccq_pkg::CLS_COAL;
		end else begin
			new_cmd.cls = ccq_pkg::CLS_FIFO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cfg.valid) begin
				mask_q <= cfg.data;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, head_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push && !wr_idx) begin
			ent0_q <= new_cmd;
		end else if (head_pop) begin
			ent0_q <= ent1_q;
		end
		if (push && wr_idx) begin
			ent1_q <= new_cmd;
		end
	end

	assign head = ent0_q;
	assign head_valid = (cnt_q != 2'd0);
endmodule

/* rtl/core/ccq_back.sv */
// Back end: ordered ring, coalescing slot table, slot search and drain sequencer.
// Depends on ccq_pkg and ccq_ram.
module ccq_back #(
	parameter int FIFO_DEPTH = 64,
	parameter int SLOT_COUNT = 48,
	parameter int DRAIN_LIMIT = 16
) (
	input logic clk,
	input logic arst_n,
	input ccq_pkg::cmd_t head,
	input logic head_valid,
	output logic head_pop,
	output ccq_pkg::result_t res,
	output logic res_valid,
	input logic res_ready
);
	localparam int EW = $bits(ccq_pkg::entry_t);
	localparam int FAW = $clog2(FIFO_DEPTH);
	localparam int SAW = SLOT_COUNT > 1 ? $clog2(SLOT_COUNT) : 1;
	localparam int SIW = $clog2(SLOT_COUNT + 1);
	localparam int CW = $clog2(DRAIN_LIMIT + 1);
	localparam int TW = $clog2(FIFO_DEPTH + SLOT_COUNT + 64);

	ccq_pkg::state_t st_q, st_d;
	ccq_pkg::cmd_t cur_q;
	ccq_pkg::res_t rtype_q;
	ccq_pkg::entry_t f_rdata, s_rdata;
	logic [FAW-1:0] wptr_q, rptr_q, w_next, r_next;
	logic [FAW:0] fdiff, fcnt;
	logic [SIW-1:0] scnt_q, sidx_q;
	logic [SAW-1:0] sidx, hit_q, free_q, s_waddr;
	logic valid_q [SLOT_COUNT];
	logic hit_ok_q, free_ok_q;
	logic [CW-1:0] cons_q;
	logic [TW-1:0] tot_now, tot_after, tot_after_q;
	logic f_we, f_re, s_we, s_re;
	logic f_full, f_empty, sidx_end, cons_lim, key_hit, f_stale, s_stale;

	assign w_next = (wptr_q == FAW'(FIFO_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
	assign r_next = (rptr_q == FAW'(FIFO_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
	assign f_full = (w_next == rptr_q);
	assign f_empty = (wptr_q == rptr_q);
	assign fdiff = {1'b0, wptr_q} - {1'b0, rptr_q};
	assign fcnt = (wptr_q >= rptr_q) ? fdiff : fdiff + (FAW + 1)'(FIFO_DEPTH);
	assign tot_now = TW'(fcnt) + TW'(scnt_q);
	assign tot_after = (tot_now > TW'(DRAIN_LIMIT)) ? tot_now - TW'(DRAIN_LIMIT) : '0;
	assign sidx = sidx_q[SAW-1:0];
	assign sidx_end = (sidx_q == SIW'(SLOT_COUNT));
	assign cons_lim = (cons_q == CW'(DRAIN_LIMIT));
	assign key_hit = (ccq_pkg::key_of(s_rdata) == ccq_pkg::key_of(cur_q.ent));
	assign f_stale = ccq_pkg::is_stale(f_rdata.gen, cur_q.active);
	assign s_stale = ccq_pkg::is_stale(s_rdata.gen, cur_q.active);
	assign s_waddr = hit_ok_q ? hit_q : free_q;

	ccq_ram #(.W(EW), .D(FIFO_DEPTH)) u_fifo_ram (
		.clk(clk), .we(f_we), .waddr(wptr_q), .wdata(cur_q.ent),
		.re(f_re), .raddr(rptr_q), .rdata(f_rdata)
	);

	ccq_ram #(.W(EW), .D(SLOT_COUNT)) u_slot_ram (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(cur_q.ent),
		.re(s_re), .raddr(sidx), .rdata(s_rdata)
	);

	always_comb begin
		st_d = st_q;
		head_pop = 1'b0;
		f_we = 1'b0;
		f_re = 1'b0;
		s_we = 1'b0;
		s_re = 1'b0;
		res_valid = 1'b0;
		res = '0;
		unique case (st_q)
			ccq_pkg::ST_IDLE: begin
				if (head_valid) begin
					head_pop = 1'b1;
					case (head.cls)
						ccq_pkg::CLS_BYPASS: st_d = ccq_pkg::ST_RESP;
						ccq_pkg::CLS_COAL: st_d = ccq_pkg::ST_SC_RD;
						ccq_pkg::CLS_FIFO: st_d = ccq_pkg::ST_FIFO_WR;
						default: st_d = ccq_pkg::ST_DF_RD;
					endcase
				end
			end
			ccq_pkg::ST_FIFO_WR: begin
				f_we = !f_full;
				st_d = ccq_pkg::ST_RESP;
			end
			ccq_pkg::ST_SC_RD: begin
				if (sidx_end) begin
					st_d = ccq_pkg::ST_SC_END;
				end else if (valid_q[sidx]) begin
					s_re = 1'b1;
					st_d = ccq_pkg::ST_SC_CMP;
				end
			end
			ccq_pkg::ST_SC_CMP: begin
				st_d = key_hit ? ccq_pkg::ST_SC_END : ccq_pkg::ST_SC_RD;
			end
			ccq_pkg::ST_SC_END: begin
				s_we = hit_ok_q || free_ok_q;
				st_d = ccq_pkg::ST_RESP;
			end
			ccq_pkg::ST_RESP: begin
				res_valid = 1'b1;
				res.rtype = rtype_q;
				if (rtype_q == ccq_pkg::RES_EXEC) begin
					res.args = cur_q.ent.args;
					res.pv = cur_q.ent.pv;
				end
				res.is_last = 1'b1;
				res.total = 7'(tot_now);
				if (res_ready) begin
					st_d = ccq_pkg::ST_IDLE;
				end
			end
			ccq_pkg::ST_DF_RD: begin
				if (cons_lim || f_empty) begin
					st_d = ccq_pkg::ST_DS_RD;
				end else begin
					f_re = 1'b1;
					st_d = ccq_pkg::ST_DF_CHK;
				end
			end
			ccq_pkg::ST_DF_CHK: begin
				if (!f_stale) begin
					res_valid = 1'b1;
					res.rtype = ccq_pkg::RES_EXEC;
					res.args = f_rdata.args;
					res.pv = f_rdata.pv;
					res.total = 7'(tot_after_q);
				end
				if (f_stale || res_ready) begin
					st_d = ccq_pkg::ST_DF_RD;
				end
			end
			ccq_pkg::ST_DS_RD: begin
				if (cons_lim || sidx_end) begin
					st_d = ccq_pkg::ST_DONE;
				end else if (valid_q[sidx]) begin
					s_re = 1'b1;
					st_d = ccq_pkg::ST_DS_CHK;
				end
			end
			ccq_pkg::ST_DS_CHK: begin
				if (!s_stale) begin
					res_valid = 1'b1;
					res.rtype = ccq_pkg::RES_EXEC;
					res.args = s_rdata.args;
					res.pv = s_rdata.pv;
					res.total = 7'(tot_after_q);
				end
				if (s_stale || res_ready) begin
					st_d = ccq_pkg::ST_DS_RD;
				end
			end
			ccq_pkg::ST_DONE: begin
				res_valid = 1'b1;
				res.rtype = ccq_pkg::RES_DONE;
				res.is_last = 1'b1;
				res.consumed = 6'(cons_q);
				res.total = 7'(tot_now);
				if (res_ready) begin
					st_d = ccq_pkg::ST_IDLE;
				end
			end
			default: st_d = ccq_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ccq_pkg::ST_IDLE;
			rtype_q <= ccq_pkg::RES_ACCEPT;
			wptr_q <= '0;
			rptr_q <= '0;
			scnt_q <= '0;
			sidx_q <= '0;
			hit_q <= '0;
			free_q <= '0;
			hit_ok_q <= 1'b0;
			free_ok_q <= 1'b0;
			cons_q <= '0;
			tot_after_q <= '0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				valid_q[i] <= 1'b0;
			end
		end else begin
			st_q <= st_d;
			case (st_q)
				ccq_pkg::ST_IDLE: begin
					if (head_valid) begin
						sidx_q <= '0;
						hit_ok_q <= 1'b0;
						free_ok_q <= 1'b0;
						cons_q <= '0;
						tot_after_q <= tot_after;
						rtype_q <= ccq_pkg::RES_EXEC;
					end
				end
				ccq_pkg::ST_FIFO_WR: begin
					rtype_q <= f_full ? ccq_pkg::RES_REJECT : ccq_pkg::RES_ACCEPT;
					if (!f_full) begin
						wptr_q <= w_next;
					end
				end
				ccq_pkg::ST_SC_RD: begin
					if (!sidx_end && !valid_q[sidx]) begin
						if (!free_ok_q) begin
							free_ok_q <= 1'b1;
							free_q <= sidx;
						end
						sidx_q <= sidx_q + 1'b1;
					end
				end
				ccq_pkg::ST_SC_CMP: begin
					if (key_hit) begin
						hit_ok_q <= 1'b1;
						hit_q <= sidx;
					end else begin
						sidx_q <= sidx_q + 1'b1;
					end
				end
				ccq_pkg::ST_SC_END: begin
					if (hit_ok_q) begin
						rtype_q <= ccq_pkg::RES_ACCEPT;
					end else if (free_ok_q) begin
						valid_q[free_q] <= 1'b1;
						scnt_q <= scnt_q + 1'b1;
						rtype_q <= ccq_pkg::RES_ACCEPT;
					end else begin
						rtype_q <= ccq_pkg::RES_REJECT;
					end
				end
				ccq_pkg::ST_DF_CHK: begin
					if (f_stale || res_ready) begin
						rptr_q <= r_next;
						cons_q <= cons_q + 1'b1;
					end
				end
				ccq_pkg::ST_DS_RD: begin
					if (!cons_lim && !sidx_end && !valid_q[sidx]) begin
						sidx_q <= sidx_q + 1'b1;
					end
				end
				ccq_pkg::ST_DS_CHK: begin
					if (s_stale || res_ready) begin
						valid_q[sidx] <= 1'b0;
						scnt_q <= scnt_q - 1'b1;
						cons_q <= cons_q + 1'b1;
						sidx_q <= sidx_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ccq_pkg::ST_IDLE && head_valid) begin
			cur_q <= head;
		end
	end
endmodule

/* rtl/core/coalescing_command_queue.sv */
// Coalescing command queue: bypass, ordered submit and coalescing submit (slot search with
// one slot read and compare at a time). A drain consumes ring entries, then slots, skipping
// empty slots, up to DRAIN_LIMIT entries; one item is worked on at a time.
// Reset is asynchronous: clears the kind mask, ring pointers and slot valid bits at once.
// Depends on ccq_pkg, ccq_ifs, ccq_front and ccq_back.
module coalescing_command_queue #(
	parameter int FIFO_DEPTH = 64,
	parameter int SLOT_COUNT = 48,
	parameter int DRAIN_LIMIT = 16
) (
	input logic clk,
	input logic arst_n,
	ccq_cfg_if.sink cfg,
	ccq_req_if.sink req,
	ccq_rsp_if.source rsp
);
	ccq_pkg::cmd_t head;
	logic head_valid, head_pop;
	ccq_pkg::result_t res, out_q;
	logic res_valid, res_ready, ov_q;

	ccq_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .req(req),
		.head(head), .head_valid(head_valid), .head_pop(head_pop)
	);

	ccq_back #(
		.FIFO_DEPTH(FIFO_DEPTH), .SLOT_COUNT(SLOT_COUNT), .DRAIN_LIMIT(DRAIN_LIMIT)
	) u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .head_valid(head_valid),
		.head_pop(head_pop), .res(res), .res_valid(res_valid), .res_ready(res_ready)
	);

	assign res_ready = !ov_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (res_ready) begin
			ov_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign rsp.valid = ov_q;
	assign rsp.result_type = out_q.rtype;
	assign rsp.out_kind = out_q.args[52:48];
	assign rsp.out_a = out_q.args[47:40];
	assign rsp.out_b = out_q.args[39:32];
	assign rsp.out_c = out_q.args[31:24];
	assign rsp.out_d = out_q.args[23:16];
	assign rsp.out_wide = out_q.args[15:0];
	assign rsp.out_param = out_q.pv[47:32];
	assign rsp.out_value = out_q.pv[31:0];
	assign rsp.is_last = out_q.is_last;
	assign rsp.consumed = out_q.consumed;
	assign rsp.queued_total = out_q.total;
endmodule

/* rtl/core/ccq_checker.sv */
// Port-level checker for the coalescing command queue, bound to the top level.
// Depends on ccq_pkg and coalescing_command_queue_assert.svh.
`include "coalescing_command_queue_assert.svh"
module ccq_props (
	input logic clk,
	input logic arst_n,
	input logic valid,
	input logic ready,
	input logic [1:0] result_type,
	input logic [4:0] out_kind,
	input logic [31:0] out_value,
	input logic is_last,
	input logic [5:0] consumed
);
	logic status_res;
	logic status_clean;

	assign status_res = (result_type == ccq_pkg::RES_ACCEPT) ||
		(result_type == ccq_pkg::RES_REJECT);
	assign status_clean = is_last && (out_kind == 5'd0) && (out_value == 32'd0);

	`CCQ_ASSERT_NEXT(a_hold, valid && !ready, valid)
	`CCQ_ASSERT_NOW(a_done_last, valid && result_type == ccq_pkg::RES_DONE, is_last)
	`CCQ_ASSERT_NOW(a_cons_done, valid && result_type != ccq_pkg::RES_DONE, consumed == 6'd0)
	`CCQ_ASSERT_NOW(a_status_clean, valid && status_res, status_clean)
endmodule

bind coalescing_command_queue ccq_props u_ccq_checker (
	.clk(clk),
	.arst_n(arst_n),
	.valid(rsp.valid),
	.ready(rsp.ready),
	.result_type(rsp.result_type),
	.out_kind(rsp.out_kind),
	.out_value(rsp.out_value),
	.is_last(rsp.is_last),
	.consumed(rsp.consumed)
);

/* sim/ccq_checker.sv */
// Checker for the coalescing command queue: watches config, request and response channels,
// predicts the results of every accepted item and compares them field by field.
// Depends on ccq_pkg and ccq_ifs.
`timescale 1ns / 1ps
module ccq_checker #(
	parameter int FIFO_DEPTH = 64,
	parameter int SLOT_COUNT = 48,
	parameter int DRAIN_LIMIT = 16
) (
	input logic clk,
	input logic arst_n,
	ccq_cfg_if.sink cfg,
	ccq_req_if.sink req,
	ccq_rsp_if.sink rsp,
	output int fail_count,
	output int pending,
	output int fifo_held,
	output int slots_held
);
	typedef struct packed {
		logic [1:0] rtype;
		logic [4:0] kind;
		logic [7:0] a, b, c, d;
		logic [15:0] wide, param;
		logic [31:0] value;
		logic is_last;
		logic [5:0] consumed;
		logic [6:0] total;
	} outcome_t;

	typedef struct packed {
		logic [4:0] kind;
		logic [7:0] a, b, c, d;
		logic [15:0] wide, param;
		logic [31:0] value;
		logic [31:0] gen;
	} command_t;

	logic [31:0] kind_mask;
	command_t ring[$];
	command_t slot_cmd[SLOT_COUNT];
	bit slot_used[SLOT_COUNT];
	outcome_t outcomes[$];

	assign pending = outcomes.size();
	assign fifo_held = ring.size();
	always_comb begin
		slots_held = 0;
		for (int i = 0; i < SLOT_COUNT; i++) slots_held += slot_used[i];
	end

	function automatic outcome_t exec_of(command_t c);
		outcome_t o;
		o = '0;
		o.rtype = ccq_pkg::RES_EXEC;
		o.kind = c.kind; o.a = c.a; o.b = c.b; o.c = c.c; o.d = c.d;
		o.wide = c.wide; o.param = c.param; o.value = c.value;
		return o;
	endfunction

	function automatic bit same_key(command_t x, command_t y);
		return x.kind == y.kind && x.a == y.a && x.b == y.b && x.c == y.c && x.param == y.param;
	endfunction

	function automatic bit expired(logic [31:0] g, logic [31:0] act);
		return g != 0 && g != act;
	endfunction

	task automatic predict_queue(command_t c, bit drain, bit bypass, logic [31:0] act);
		outcome_t batch[$];
		outcome_t o;
		int hit, taken, held;
		o = '0;
		if (!drain) begin
			if (bypass) o = exec_of(c);
			else if (kind_mask[c.kind]) begin
				hit = -1;
				for (int i = 0; i < SLOT_COUNT && hit < 0; i++)
					if (slot_used[i] && same_key(slot_cmd[i], c)) hit = i;
				for (int i = 0; i < SLOT_COUNT && hit < 0; i++)
					if (!slot_used[i]) hit = i;
				if (hit >= 0) begin
					slot_cmd[hit] = c;
					slot_used[hit] = 1;
					o.rtype = ccq_pkg::RES_ACCEPT;
				end else o.rtype = ccq_pkg::RES_REJECT;
			end else if (ring.size() >= FIFO_DEPTH - 1) o.rtype = ccq_pkg::RES_REJECT;
			else begin
				ring.push_back(c);
				o.rtype = ccq_pkg::RES_ACCEPT;
			end
			batch.push_back(o);
		end else begin
			taken = 0;
			while (ring.size() > 0 && taken < DRAIN_LIMIT) begin
				command_t r;
				r = ring.pop_front();
				taken++;
				if (!expired(r.gen, act)) batch.push_back(exec_of(r));
			end
			for (int i = 0; i < SLOT_COUNT && taken < DRAIN_LIMIT; i++) begin
				if (!slot_used[i]) continue;
				slot_used[i] = 0;
				taken++;
				if (!expired(slot_cmd[i].gen, act)) batch.push_back(exec_of(slot_cmd[i]));
			end
			o.rtype = ccq_pkg::RES_DONE;
			o.consumed = taken[5:0];
			batch.push_back(o);
		end
		held = ring.size();
		for (int i = 0; i < SLOT_COUNT; i++) held += slot_used[i];
		foreach (batch[k]) begin
			batch[k].total = held[6:0];
			batch[k].is_last = (k == batch.size() - 1);
			outcomes.push_back(batch[k]);
		end
	endtask

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		command_t c;
		outcome_t g, w;
		if (!arst_n) begin
			kind_mask = '0;
			ring.delete();
			outcomes.delete();
			for (int i = 0; i < SLOT_COUNT; i++) slot_used[i] = 0;
			fail_count = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				g = '{rsp.result_type, rsp.out_kind, rsp.out_a, rsp.out_b, rsp.out_c, rsp.out_d,
					rsp.out_wide, rsp.out_param, rsp.out_value, rsp.is_last, rsp.consumed,
					rsp.queued_total};
				if (outcomes.size() == 0) report("unexpected item", g.rtype, 0);
				else begin
					w = outcomes.pop_front();
					if (g.rtype !== w.rtype) report("result_type", g.rtype, w.rtype);
					if (g.kind !== w.kind) report("out_kind", g.kind, w.kind);
					if (g.a !== w.a) report("out_a", g.a, w.a);
					if (g.b !== w.b) report("out_b", g.b, w.b);
					if (g.c !== w.c) report("out_c", g.c, w.c);
					if (g.d !== w.d) report("out_d", g.d, w.d);
					if (g.wide !== w.wide) report("out_wide", g.wide, w.wide);
					if (g.param !== w.param) report("out_param", g.param, w.param);
					if (g.value !== w.value) report("out_value", g.value, w.value);
					if (g.is_last !== w.is_last) report("is_last", g.is_last, w.is_last);
					if (g.consumed !== w.consumed) report("consumed", g.consumed, w.consumed);
					if (g.total !== w.total) report("queued_total", g.total, w.total);
				end
			end
			if (cfg.valid && cfg.ready) kind_mask = cfg.data;
			if (req.valid && req.ready) begin
				c = '{req.kind, req.arg_a, req.arg_b, req.arg_c, req.arg_d, req.wide_arg,
					req.param_key, req.payload_value, req.generation};
				predict_queue(c, req.cmd, req.bypass, req.live_generation);
			end
		end
	end
endmodule

/* sim/tb.sv */
// Testbench top for the coalescing command queue: clock, reset, directed and random
// submit/drain stimulus across idle phases and mask settings, and the verdict.
// Depends on ccq_pkg, ccq_ifs, coalescing_command_queue and ccq_checker.
`timescale 1ns / 1ps
module tb;
	localparam int STALL_LIMIT = 20000;

	logic clk;
	logic arst_n;
	int fail_count, pending, fifo_held, slots_held;
	int send_idle, recv_idle;
	int quiet_cycles;
	logic [31:0] cur_gen;

	ccq_cfg_if cfg();
	ccq_req_if req();
	ccq_rsp_if rsp();

	coalescing_command_queue dut(.clk(clk), .arst_n(arst_n), .cfg(cfg), .req(req), .rsp(rsp));
	ccq_checker chk(.clk(clk), .arst_n(arst_n), .cfg(cfg), .req(req), .rsp(rsp),
		.fail_count(fail_count), .pending(pending), .fifo_held(fifo_held),
		.slots_held(slots_held));

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		rsp.ready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		if (req.valid && req.ready || rsp.valid && rsp.ready || cfg.valid && cfg.ready)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog expired");
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic write_mask(logic [31:0] m);
		@(negedge clk);
		cfg.valid <= 1;
		cfg.data <= m;
		do @(posedge clk); while (!(cfg.valid && cfg.ready));
		@(negedge clk);
		cfg.valid <= 0;
	endtask

	// called at a falling edge; leaves valid high so the next item can follow at once
	task automatic send_item(bit drain, bit bypass, logic [4:0] kind, logic [7:0] a,
			logic [7:0] b, logic [7:0] c, logic [7:0] d, logic [15:0] w, logic [15:0] p,
			logic [31:0] v, logic [31:0] g, logic [31:0] act);
		while ($urandom_range(99) < send_idle) begin
			req.valid <= 0;
			@(negedge clk);
		end
		req.valid <= 1;
		req.cmd <= drain;
		req.bypass <= bypass;
		req.kind <= kind;
		req.arg_a <= a; req.arg_b <= b; req.arg_c <= c; req.arg_d <= d;
		req.wide_arg <= w;
		req.param_key <= p;
		req.payload_value <= v;
		req.generation <= g;
		req.live_generation <= act;
		do @(posedge clk); while (!(req.valid && req.ready));
		@(negedge clk);
	endtask

	task automatic send_random();
		int sel;
		logic [31:0] g;
		sel = $urandom_range(99);
		case ($urandom_range(3))
			0: g = 0;
			1: g = cur_gen;
			2: g = cur_gen - 1;
			default: g = $urandom;
		endcase
		if (sel < 18) begin
			if ($urandom_range(7) == 0) cur_gen = $urandom;
			else if ($urandom_range(3) == 0) cur_gen++;
			send_item(1, 1'($urandom_range(1)), 5'($urandom), 8'($urandom), 8'($urandom),
				8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), $urandom, $urandom,
				cur_gen);
		end else if (sel < 60)
			send_item(0, sel < 24, 5'($urandom), 8'($urandom_range(3)), 8'($urandom_range(1)),
				8'($urandom_range(1)), 8'($urandom), 16'($urandom), 16'($urandom_range(3)),
				$urandom, g, $urandom);
		else
			send_item(0, sel < 64, 5'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
				8'($urandom), 16'($urandom), 16'($urandom), $urandom, g, $urandom);
	endtask

	task automatic settle();
		req.valid <= 0;
		wait (pending == 0);
		repeat (150) @(posedge clk);
	endtask

	task automatic drain_all();
		while (fifo_held + slots_held > 0) send_item(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		settle();
	endtask

	initial begin
		arst_n = 0;
		cfg.valid = 0; cfg.data = 0;
		req.valid = 0; req.cmd = 0; req.bypass = 0; req.kind = 0;
		req.arg_a = 0; req.arg_b = 0; req.arg_c = 0; req.arg_d = 0;
		req.wide_arg = 0; req.param_key = 0; req.payload_value = 0;
		req.generation = 0; req.live_generation = 0;
		rsp.ready = 1;
		send_idle = 0; recv_idle = 0;
		quiet_cycles = 0;
		cur_gen = 5;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: empty drain, bypass, fifo path, stale, coalesce hit, extremes
		send_item(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_item(0, 1, 31, 255, 255, 255, 255, 16'hffff, 16'hffff, '1, '1, '1);
		send_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_item(0, 0, 31, 255, 255, 255, 255, 16'hffff, 16'hffff, '1, '1, 0);
		send_item(0, 0, 3, 1, 2, 3, 4, 5, 6, 7, 9, 0);
		send_item(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 9);
		settle();
		write_mask('1);
		send_item(0, 0, 7, 1, 2, 3, 4, 5, 6, 7, 0, 0);
		send_item(0, 0, 7, 1, 2, 3, 9, 9, 6, 99, 0, 0);
		send_item(0, 0, 7, 1, 2, 4, 4, 5, 6, 7, 3, 0);
		send_item(0, 0, 31, 255, 255, 255, 255, 16'hffff, 16'hffff, '1, '1, 0);
		send_item(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 3);
		// fill table, then reject
		for (int i = 0; i < 49; i++)
			send_item(0, 0, i[4:0], i[7:0], 0, 0, 0, 0, 16'h1234, i, 0, 0);
		drain_all();
		write_mask(0);
		// fill fifo, then reject
		for (int i = 0; i < 64; i++)
			send_item(0, 0, i[4:0], 0, 0, 0, 0, 0, 0, i, 0, 0);
		drain_all();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle = 0; recv_idle = 0; end
				1: begin send_idle = 78; recv_idle = 0; end
				2: begin send_idle = 0; recv_idle = 78; end
				default: begin send_idle = 23; recv_idle = 23; end
			endcase
			settle();
			case (ph)
				0: write_mask(32'h0000ffff);
				1: write_mask($urandom);
				2: write_mask('1);
				default: write_mask(32'h80000001);
			endcase
			for (int n = 0; n < 80; n++) begin
				send_random();
				if (n == 40) begin
					req.valid <= 0;
					wait (pending == 0);
					@(negedge clk);
				end
			end
		end
		drain_all();
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
